### rtl/cts_pkg.sv
package cts_pkg;

   localparam int BYTE_W          = 8;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_INDEX_W     = 2;
   localparam int LEN_W           = 3;
   localparam int MAX_TAG_DEFAULT = 4;
   // power of two
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [BYTE_W-1:0]     NEWLINE_BYTE    = 8'h0A;
   localparam logic [CSR_DATA_W-1:0] START_TAG_RESET = 32'h0000_2A2F;
   localparam logic [LEN_W-1:0]      START_LEN_RESET = 3'd2;
   localparam logic [CSR_DATA_W-1:0] END_TAG_RESET   = 32'h0000_2F2A;
   localparam logic [LEN_W-1:0]      END_LEN_RESET   = 3'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_TAG = 2'd0,
      CSR_START_LEN = 2'd1,
      CSR_END_TAG   = 2'd2,
      CSR_END_LEN   = 2'd3
   } cts_csr_index_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] start_tag;
      logic [LEN_W-1:0]      start_len;
      logic [CSR_DATA_W-1:0] end_tag;
      logic [LEN_W-1:0]      end_len;
   } cts_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              eoi;
      logic              flush;
   } cts_item_type;

   // tag bytes beyond the register compare as zero
   function automatic logic [BYTE_W-1:0] cts_tag_byte(input logic [CSR_DATA_W-1:0] tag,
                                                       input int k);
      logic [CSR_DATA_W-1:0] shifted;
      shifted = tag >> (BYTE_W * k);
      return shifted[BYTE_W-1:0];
   endfunction

endpackage

### rtl/cts_front.sv
module cts_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cts_pkg::BYTE_W-1:0]  req_tdata,   // in_byte
   input  logic                        req_tlast,   // end_of_input
   output logic                        item_valid,
   input  logic                        item_ready,
   output cts_pkg::cts_item_type       item
);
   import cts_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cts_item_type  entry_ff [QUEUE_DEPTH];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   cts_item_type  classified;
   logic          push, pop;

   // classify: newline or end of input flushes the window
   always_comb begin
      classified.data  = req_tdata;
      classified.eoi   = req_tlast;
      classified.flush = req_tlast || (req_tdata == NEWLINE_BYTE);
   end

   assign req_tready = (count_ff != CW'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

### rtl/cts_back.sv
module cts_back #(
   parameter int MAX_TAG = cts_pkg::MAX_TAG_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cts_pkg::cts_cfg_type        cfg,
   input  logic                        item_valid,
   output logic                        item_ready,
   input  cts_pkg::cts_item_type       item,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cts_pkg::BYTE_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast
);
   import cts_pkg::*;

   localparam int FW = $clog2(MAX_TAG + 1);
   localparam int LW = (FW > LEN_W) ? FW : LEN_W;
   localparam int WW = MAX_TAG * BYTE_W;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type         state_ff, state_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic              inside_ff, inside_in;
   logic              held_valid_ff, held_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]     window_ff, window_in;
   logic              flush_ff, flush_in;
   logic              eoi_ff, eoi_in;
   logic [BYTE_W-1:0] held_byte_ff, held_byte_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CSR_DATA_W-1:0] tag;
   logic [LEN_W-1:0]      len_raw;
   logic [LW-1:0]         len_ext;
   logic [FW-1:0]         len;
   logic [MAX_TAG-1:0]    byte_ok;
   logic                  head_match;
   logic                  act_match, act_drop;
   logic                  emit;
   logic [BYTE_W-1:0]     emit_byte;
   logic [FW-1:0]         shift_n;
   logic [WW-1:0]         window_shifted;
   logic                  out_free;

   // tag and clamped length for the current state
   always_comb begin
      tag     = inside_ff ? cfg.end_tag : cfg.start_tag;
      len_raw = inside_ff ? cfg.end_len : cfg.start_len;
      len_ext = LW'(len_raw);
      if (len_ext == '0) begin
         len = FW'(1);
      end else if (len_ext > LW'(MAX_TAG)) begin
         len = FW'(MAX_TAG);
      end else begin
         len = FW'(len_ext);
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_TAG; k++) begin
         byte_ok[k] = (FW'(k) >= len) ||
                      (window_ff[BYTE_W*k +: BYTE_W] == cts_tag_byte(tag, k));
      end
   end

   assign head_match     = &byte_ok;
   assign act_match      = (fill_ff != '0) && (fill_ff >= len) && head_match;
   assign act_drop       = (fill_ff != '0) && !act_match && ((fill_ff >= len) || flush_ff);
   assign shift_n        = act_match ? len : FW'(1);
   assign window_shifted = window_ff >> {shift_n, 3'b000};
   assign out_free       = !rsp_valid_ff || rsp_tready;

   always_comb begin
      emit      = 1'b0;
      emit_byte = window_ff[BYTE_W-1:0];
      if (act_match) begin
         emit      = inside_ff;
         emit_byte = NEWLINE_BYTE;
      end else if (act_drop) begin
         emit = !inside_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      inside_in     = inside_ff;
      held_valid_in = held_valid_ff;
      window_in     = window_ff;
      flush_in      = flush_ff;
      eoi_in        = eoi_ff;
      held_byte_in  = held_byte_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      item_ready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               for (int i = 0; i < MAX_TAG; i++) begin
                  if (FW'(i) == fill_ff) begin
                     window_in[BYTE_W*i +: BYTE_W] = item.data;
                  end
               end
               fill_in  = fill_ff + FW'(1);
               flush_in = item.flush;
               eoi_in   = item.eoi;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (act_match || act_drop) begin
               if (!(emit && held_valid_ff && !out_free)) begin
                  window_in = window_shifted;
                  fill_in   = fill_ff - shift_n;
                  if (act_match) begin
                     inside_in = !inside_ff;
                  end
                  if (emit) begin
                     if (held_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_byte_in  = held_byte_ff;
                        rsp_last_in  = 1'b0;
                     end
                     held_valid_in = 1'b1;
                     held_byte_in  = emit_byte;
                  end
               end
            end else if (!held_valid_ff || out_free) begin
               // run complete: release the held byte as the last one
               if (held_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = held_byte_ff;
                  rsp_last_in  = 1'b1;
               end
               held_valid_in = 1'b0;
               if (eoi_ff) begin
                  inside_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         inside_ff     <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         inside_ff     <= inside_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff    <= window_in;
      flush_ff     <= flush_in;
      eoi_ff       <= eoi_in;
      held_byte_ff <= held_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/comment_tag_stripper.sv
// Removes tagged comments from a byte stream. Outside a comment each byte passes unless the
// start tag matches at the head of a window of up to MAX_TAG bytes; inside a comment bytes are
// dropped until the end tag matches, and one newline then stands for the whole comment. A
// newline byte or tlast flushes the window, so tags never span lines; tlast also ends any open
// comment. rsp_tlast marks the last output byte caused by one input transaction, and an input
// transaction may cause none. Input transactions go into a two-entry queue; the window sequencer
// behind it takes one transaction at a time, loads its byte into the window and makes window
// decisions (a byte kept or dropped, or a tag matched) until none is due; rsp_tready may stall
// it. The user must write tags and lengths through the csr port only while no transaction is
// in flight; the block does not enforce it. Length 0 acts as 1, one above MAX_TAG as MAX_TAG.
module comment_tag_stripper #(
   parameter int MAX_TAG = cts_pkg::MAX_TAG_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cts_pkg::BYTE_W-1:0]      req_tdata,   // in_byte
   input  logic                            req_tlast,   // end_of_input
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cts_pkg::BYTE_W-1:0]      rsp_tdata,   // out_byte
   output logic                            rsp_tlast,   // last_of_run
   input  logic                            csr_wen,
   input  logic [cts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cts_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cts_pkg::*;

   logic [CSR_DATA_W-1:0] start_tag_ff, start_tag_in;
   logic [LEN_W-1:0]      start_len_ff, start_len_in;
   logic [CSR_DATA_W-1:0] end_tag_ff, end_tag_in;
   logic [LEN_W-1:0]      end_len_ff, end_len_in;
   cts_cfg_type           cfg;
   logic                  item_valid, item_ready;
   cts_item_type          item;

   always_comb begin
      start_tag_in = start_tag_ff;
      start_len_in = start_len_ff;
      end_tag_in   = end_tag_ff;
      end_len_in   = end_len_ff;
      if (csr_wen) begin
         unique case (cts_csr_index_type'(csr_index))
            CSR_START_TAG: start_tag_in = csr_wdata;
            CSR_START_LEN: start_len_in = csr_wdata[LEN_W-1:0];
            CSR_END_TAG:   end_tag_in   = csr_wdata;
            CSR_END_LEN:   end_len_in   = csr_wdata[LEN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_tag_ff <= START_TAG_RESET;
         start_len_ff <= START_LEN_RESET;
         end_tag_ff   <= END_TAG_RESET;
         end_len_ff   <= END_LEN_RESET;
      end else begin
         start_tag_ff <= start_tag_in;
         start_len_ff <= start_len_in;
         end_tag_ff   <= end_tag_in;
         end_len_ff   <= end_len_in;
      end
   end

   always_comb begin
      cfg.start_tag = start_tag_ff;
      cfg.start_len = start_len_ff;
      cfg.end_tag   = end_tag_ff;
      cfg.end_len   = end_len_ff;
   end

   cts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   cts_back #(
      .MAX_TAG (MAX_TAG)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
